/* rtl/sbd_pkg.sv */
// Shared types, codes and the opcode table for the script bytecode decoder.
`timescale 1ns / 1ps

package sbd_pkg;

  localparam int MAX_LABELS_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int LBL_ID_W  = 8;
  localparam int TARGET_W  = 16;
  localparam int ENTRY_W   = LBL_ID_W + TARGET_W;
  localparam int NUM_ARGS  = 5;
  localparam int KNOWN_OPS = 20;

  // Input operations
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNKNOWN   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam logic [15:0] KNOWN_CODE [KNOWN_OPS] = '{
    16'h1070, 16'h1330, 16'h1350, 16'h1360, 16'h1370, 16'h1420, 16'h1430,
    16'h1510, 16'h1520, 16'h2005, 16'h2010, 16'h2014, 16'h3010, 16'h3020,
    16'h30ff, 16'h4000, 16'hf010, 16'hf200, 16'hfff0, 16'hffff
  };

  localparam logic [2:0] KNOWN_ARGS [KNOWN_OPS] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0,
    3'd0, 3'd5, 3'd4, 3'd3, 3'd0, 3'd0, 3'd1,
    3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd0
  };

  typedef struct packed {
    logic       known;
    logic [2:0] nargs;
  } op_info_t;

  // Controller to datapath commands
  typedef struct packed {
    logic push;
    logic restart;
    logic lk_load;
    logic rd_en;
    logic lk_emit;
    logic lk_hit;
  } sbd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic id_match;
  } sbd_sts_t;

  function automatic op_info_t op_lookup(input logic [15:0] code);
    op_info_t info;
    info = '0;
    for (int i = 0; i < KNOWN_OPS; i++) begin
      if (KNOWN_CODE[i] == code) begin
        info.known = 1'b1;
        info.nargs = KNOWN_ARGS[i];
      end
    end
    return info;
  endfunction

endpackage

/* rtl/sbd_if.sv */
// Valid/ready channel interfaces for decoder input items and results.
`timescale 1ns / 1ps

interface sbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] label_id;

  modport source (output valid, output op, output data_byte, output last_byte,
                  output label_id, input ready);
  modport sink (input valid, input op, input data_byte, input last_byte,
                input label_id, output ready);
endinterface

interface sbd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] offset_out;
  logic [15:0] opcode;
  logic        is_label;
  logic [2:0]  word_count;
  logic [15:0] arg_a;
  logic [15:0] arg_b;
  logic [15:0] arg_c;
  logic [15:0] arg_d;
  logic [15:0] arg_e;
  logic [2:0]  status;
  logic        end_of_script;

  modport source (output valid, output offset_out, output opcode, output is_label,
                  output word_count, output arg_a, output arg_b, output arg_c,
                  output arg_d, output arg_e, output status, output end_of_script,
                  input ready);
  modport sink (input valid, input offset_out, input opcode, input is_label,
                input word_count, input arg_a, input arg_b, input arg_c,
                input arg_d, input arg_e, input status, input end_of_script,
                output ready);
endinterface

/* rtl/script_bytecode_decoder.sv */
// Pushed bytes: one per cycle while no lookup runs and the output is not stalled; a result is
// registered in the cycle after its byte. Byte rate is set by the combinational decode path
// and the one-entry output register. Lookups scan stored labels through the label RAM read port.
// Synchronous active-low reset clears decode state, label count and the output valid flag;
// the label RAM is not cleared, only entries below the label count are ever read.
`timescale 1ns / 1ps

module script_bytecode_decoder #(
  parameter int MAX_LABELS  = sbd_pkg::MAX_LABELS_DEF,
  parameter int OFFSET_BITS = sbd_pkg::OFFSET_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sbd_in_if.sink     in_ch,
  sbd_out_if.source  out_ch
);

  localparam int CW = $clog2(MAX_LABELS + 1);

  sbd_pkg::sbd_cmd_t cmd;
  sbd_pkg::sbd_sts_t sts;
  logic [CW-1:0]     rd_idx;

  sbd_ctrl #(
    .MAX_LABELS(MAX_LABELS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_op   (in_ch.op),
    .in_ready(in_ch.ready),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .sts     (sts)
  );

  sbd_dp #(
    .MAX_LABELS (MAX_LABELS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_idx           (rd_idx),
    .sts              (sts),
    .in_data_byte     (in_ch.data_byte),
    .in_last_byte     (in_ch.last_byte),
    .in_label_id      (in_ch.label_id),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_offset_out   (out_ch.offset_out),
    .out_opcode       (out_ch.opcode),
    .out_is_label     (out_ch.is_label),
    .out_word_count   (out_ch.word_count),
    .out_arg_a        (out_ch.arg_a),
    .out_arg_b        (out_ch.arg_b),
    .out_arg_c        (out_ch.arg_c),
    .out_arg_d        (out_ch.arg_d),
    .out_arg_e        (out_ch.arg_e),
    .out_status       (out_ch.status),
    .out_end_of_script(out_ch.end_of_script)
  );

endmodule

/* rtl/sbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sbd_ctrl.sv */
// Controller: input handshake, operation dispatch and label table scan sequencing.
`timescale 1ns / 1ps

module sbd_ctrl #(
  parameter int MAX_LABELS = sbd_pkg::MAX_LABELS_DEF,
  localparam int CW = $clog2(MAX_LABELS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_ready,
  output sbd_pkg::sbd_cmd_t cmd,
  output logic [CW-1:0]    rd_idx,
  input  sbd_pkg::sbd_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_LK_RD, S_LK_CMP} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          accept;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE) && sts.out_free;
    accept    = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            sbd_pkg::OP_PUSH:    cmd.push = 1'b1;
            sbd_pkg::OP_LOOKUP: begin
              cmd.lk_load = 1'b1;
              idx_nxt     = '0;
              state_nxt   = S_LK_RD;
            end
            sbd_pkg::OP_RESTART: cmd.restart = 1'b1;
            default: ;
          endcase
        end
      end
      S_LK_RD: begin
        if (sts.scan_end) begin
          // table exhausted: report a miss once the output stage is free
          if (sts.out_free) begin
            cmd.lk_emit = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (sts.id_match) begin
          if (sts.out_free) begin
            cmd.lk_emit = 1'b1;
            cmd.lk_hit  = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LK_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign rd_idx = idx_r;

endmodule

/* rtl/sbd_dp.sv */
// Datapath: byte assembly, opcode decode, label table and result register.
`timescale 1ns / 1ps

module sbd_dp #(
  parameter int MAX_LABELS  = sbd_pkg::MAX_LABELS_DEF,
  parameter int OFFSET_BITS = sbd_pkg::OFFSET_BITS_DEF,
  localparam int CW = $clog2(MAX_LABELS + 1),
  localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbd_pkg::sbd_cmd_t cmd,
  input  logic [CW-1:0]     rd_idx,
  output sbd_pkg::sbd_sts_t sts,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic [15:0]       in_label_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_offset_out,
  output logic [15:0]       out_opcode,
  output logic              out_is_label,
  output logic [2:0]        out_word_count,
  output logic [15:0]       out_arg_a,
  output logic [15:0]       out_arg_b,
  output logic [15:0]       out_arg_c,
  output logic [15:0]       out_arg_d,
  output logic [15:0]       out_arg_e,
  output logic [2:0]        out_status,
  output logic              out_end_of_script
);

  localparam int NA = sbd_pkg::NUM_ARGS;
  localparam int TW = sbd_pkg::TARGET_W;
  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;

  // Decode state
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [3:0]             bii_r, bii_nxt;
  logic [7:0]             low_r, low_nxt;
  logic [15:0]            opc_r, opc_nxt;
  logic [2:0]             exp_r, exp_nxt;
  logic [15:0]            args_r [NA];
  logic [15:0]            args_nxt [NA];
  logic                   err_r, err_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [15:0]            lk_id_r;

  // Result register
  logic        out_valid_r;
  logic [15:0] out_offset_r, out_opcode_r;
  logic        out_label_r;
  logic [2:0]  out_cnt_r, out_status_r;
  logic [15:0] out_args_r [NA];
  logic        out_eos_r;

  // Push result
  logic                   p_emit;
  logic [2:0]             p_status;
  logic [15:0]            p_opc;
  logic                   p_label;
  logic [2:0]             p_cnt;
  logic [15:0]            p_args [NA];
  logic [OFFSET_BITS-1:0] start_v;
  logic [15:0]            opc_v;
  logic [3:0]             k_v, bii_inc;
  sbd_pkg::op_info_t      info;

  // Label table
  logic                            ram_we;
  logic [sbd_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;

  sbd_ram #(
    .WIDTH(sbd_pkg::ENTRY_W),
    .DEPTH(MAX_LABELS)
  ) u_lbl_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    sts.out_free = !out_valid_r || out_ready;
    sts.scan_end = (rd_idx >= cnt_r);
    sts.id_match = ({8'h00, ram_rdata[sbd_pkg::ENTRY_W-1:TW]} == lk_id_r);
  end

  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    bii_nxt   = bii_r;
    low_nxt   = low_r;
    opc_nxt   = opc_r;
    exp_nxt   = exp_r;
    args_nxt  = args_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    p_emit    = 1'b0;
    p_status  = sbd_pkg::ST_OK;
    p_opc     = '0;
    p_label   = 1'b0;
    p_cnt     = '0;
    for (int j = 0; j < NA; j++) p_args[j] = '0;
    ram_we    = 1'b0;
    start_v   = (bii_r == 4'd0) ? pos_r : start_r;
    opc_v     = {in_data_byte, low_r};
    info      = sbd_pkg::op_lookup(opc_v);
    k_v       = bii_r - 4'd2;
    bii_inc   = bii_r + 4'd1;
    ram_wdata = {opc_v[7:0], TW'(pos_r + OFFSET_BITS'(1))};

    if (cmd.push && !err_r) begin
      start_nxt = start_v;
      if (pos_r == POS_LIMIT) begin
        p_emit   = 1'b1;
        p_status = sbd_pkg::ST_TOO_LONG;
        p_opc    = (bii_r >= 4'd2) ? opc_r : 16'h0000;
        err_nxt  = 1'b1;
      end else begin
        pos_nxt = pos_r + OFFSET_BITS'(1);
        if (bii_r == 4'd0) begin
          low_nxt = in_data_byte;
          opc_nxt = '0;
          exp_nxt = '0;
          for (int j = 0; j < NA; j++) args_nxt[j] = '0;
          bii_nxt = 4'd1;
          if (in_last_byte) begin
            p_emit   = 1'b1;
            p_status = sbd_pkg::ST_TRUNC;
            err_nxt  = 1'b1;
          end
        end else if (bii_r == 4'd1) begin
          opc_nxt = opc_v;
          if (!info.known) begin
            if (opc_v[15:8] != 8'h00) begin
              p_emit   = 1'b1;
              p_status = sbd_pkg::ST_UNKNOWN;
              p_opc    = opc_v;
              err_nxt  = 1'b1;
            end else if (cnt_r == CW'(MAX_LABELS)) begin
              p_emit   = 1'b1;
              p_status = sbd_pkg::ST_FULL;
              p_opc    = opc_v;
              err_nxt  = 1'b1;
            end else begin
              // label marker: record id and the offset right after it
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              p_emit  = 1'b1;
              p_opc   = opc_v;
              p_label = 1'b1;
              bii_nxt = 4'd0;
            end
          end else if (info.nargs == 3'd0) begin
            exp_nxt = '0;
            p_emit  = 1'b1;
            p_opc   = opc_v;
            bii_nxt = 4'd0;
          end else begin
            exp_nxt = info.nargs;
            bii_nxt = 4'd2;
            if (in_last_byte) begin
              p_emit   = 1'b1;
              p_status = sbd_pkg::ST_TRUNC;
              p_opc    = opc_v;
              err_nxt  = 1'b1;
            end
          end
        end else begin
          // argument bytes: even ones hold the low half, odd ones complete a word
          if (!k_v[0]) begin
            low_nxt = in_data_byte;
          end else begin
            for (int j = 0; j < NA; j++) begin
              if (k_v[3:1] == 3'(j)) args_nxt[j] = {in_data_byte, low_r};
            end
          end
          bii_nxt = bii_inc;
          if (bii_inc >= 4'd2 + {exp_r, 1'b0}) begin
            p_emit  = 1'b1;
            p_opc   = opc_r;
            p_cnt   = exp_r;
            p_args  = args_nxt;
            bii_nxt = 4'd0;
          end else if (in_last_byte) begin
            p_emit   = 1'b1;
            p_status = sbd_pkg::ST_TRUNC;
            p_opc    = opc_r;
            err_nxt  = 1'b1;
          end
        end
      end
    end

    if (cmd.restart) begin
      pos_nxt   = '0;
      start_nxt = '0;
      bii_nxt   = '0;
      low_nxt   = '0;
      opc_nxt   = '0;
      exp_nxt   = '0;
      for (int j = 0; j < NA; j++) args_nxt[j] = '0;
      err_nxt   = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      bii_r   <= '0;
      low_r   <= '0;
      opc_r   <= '0;
      exp_r   <= '0;
      for (int j = 0; j < NA; j++) args_r[j] <= '0;
      err_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      bii_r   <= bii_nxt;
      low_r   <= low_nxt;
      opc_r   <= opc_nxt;
      exp_r   <= exp_nxt;
      args_r  <= args_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_load) begin
      lk_id_r <= in_label_id;
    end
  end

  // Result register: load on a push result or a lookup answer, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.push && p_emit) || cmd.lk_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && p_emit) begin
      out_offset_r <= 16'(start_v);
      out_opcode_r <= p_opc;
      out_label_r  <= p_label;
      out_cnt_r    <= p_cnt;
      out_args_r   <= p_args;
      out_status_r <= p_status;
      out_eos_r    <= in_last_byte;
    end else if (cmd.lk_emit) begin
      out_offset_r <= cmd.lk_hit ? ram_rdata[TW-1:0] : 16'h0000;
      out_opcode_r <= lk_id_r;
      out_label_r  <= cmd.lk_hit;
      out_cnt_r    <= '0;
      for (int j = 0; j < NA; j++) out_args_r[j] <= '0;
      out_status_r <= cmd.lk_hit ? sbd_pkg::ST_OK : sbd_pkg::ST_NOT_FOUND;
      out_eos_r    <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_offset_out    = out_offset_r;
  assign out_opcode        = out_opcode_r;
  assign out_is_label      = out_label_r;
  assign out_word_count    = out_cnt_r;
  assign out_arg_a         = out_args_r[0];
  assign out_arg_b         = out_args_r[1];
  assign out_arg_c         = out_args_r[2];
  assign out_arg_d         = out_args_r[3];
  assign out_arg_e         = out_args_r[4];
  assign out_status        = out_status_r;
  assign out_end_of_script = out_eos_r;

endmodule
